// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication checked outside reset
`define CHK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property checked at every edge
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/hmbs_pkg.sv =====
// package for the heightmap bilinear sampler: widths, defaults, register addresses
// no dependencies
package hmbs_pkg;
   localparam int GRID_SIDE_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int SCALE_W = 24;
   localparam int IDX_W = 12;
   localparam int ADDR_W = 4;
   localparam logic [23:0] CELL_SCALE_RST = 24'd41288;
   localparam logic [ADDR_W-1:0] REG_ORIGIN_X = 4'h0;
   localparam logic [ADDR_W-1:0] REG_ORIGIN_Z = 4'h4;
   localparam logic [ADDR_W-1:0] REG_CELL_SCALE = 4'h8;
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic                  is_query;
      logic                  ok;
      logic [COORD_W-1:0]    load_data;
      logic [IDX_W-1:0]      load_idx;
      logic                  load_en;
      logic [7:0]            cx;
      logic [7:0]            cz;
      logic [23:0]           tx;
      logic [23:0]           tz;
   } cmd_type;
endpackage

// ===== rtl/hmbs_front.sv =====
// front part: two-stage coordinate mapping and item classification
// depends on hmbs_pkg
module hmbs_front #(
   parameter int GRID_SIDE = hmbs_pkg::GRID_SIDE_DEF,
   parameter int FRAC_BITS = hmbs_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic                   kind,
   input  logic [11:0]            write_index,
   input  logic signed [31:0]     sample_height,
   input  logic signed [31:0]     world_x,
   input  logic signed [31:0]     world_z,
   input  logic signed [31:0]     origin_x,
   input  logic signed [31:0]     origin_z,
   input  logic [23:0]            cell_scale,
   output logic                   cmd_valid,
   input  logic                   cmd_stall,
   output hmbs_pkg::cmd_type      cmd
);
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int SH = 32 - FRAC_BITS;

   // stage 1 registers: local offsets
   logic s1_valid_ff, s1_valid_in;
   logic s1_kind_ff;
   logic signed [32:0] s1_lx_ff, s1_lz_ff;
   logic [11:0] s1_idx_ff;
   logic [31:0] s1_data_ff;
   logic s1_loaded_ff;
   logic loaded_ff, loaded_in;
   // stage 2 registers: classified item
   logic s2_valid_ff, s2_valid_in;
   hmbs_pkg::cmd_type s2_ff, s2_in;

   logic adv2, adv1;
   assign adv2 = !s2_valid_ff || !cmd_stall;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_stall = !adv1;
   assign cmd_valid = s2_valid_ff;
   assign cmd = s2_ff;

   // loaded flag follows the last entry write
   always_comb begin
      loaded_in = loaded_ff;
      if (in_valid && adv1 && kind == hmbs_pkg::KIND_LOAD &&
          {20'd0, write_index} == 32'(CELLS - 1))
         loaded_in = 1'b1;
   end

   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   // stage 2 mapping: scale and range test
   logic signed [57:0] px, pz;
   logic [57:0] gx, gz;
   logic okx, okz;
   always_comb begin
      px = s1_lx_ff * $signed({1'b0, cell_scale});
      pz = s1_lz_ff * $signed({1'b0, cell_scale});
      gx = 58'(px) >> SH;
      gz = 58'(pz) >> SH;
      okx = !px[57] && gx < (58'(GRID_SIDE - 1) << FRAC_BITS);
      okz = !pz[57] && gz < (58'(GRID_SIDE - 1) << FRAC_BITS);
      s2_in = '0;
      s2_in.is_query = s1_kind_ff;
      s2_in.ok = s1_loaded_ff && okx && okz;
      s2_in.load_data = s1_data_ff;
      s2_in.load_idx = s1_idx_ff;
      s2_in.load_en = !s1_kind_ff && {20'd0, s1_idx_ff} < 32'(CELLS);
      s2_in.cx = 8'(gx >> FRAC_BITS);
      s2_in.cz = 8'(gz >> FRAC_BITS);
      s2_in.tx = 24'(gx & ((58'd1 << FRAC_BITS) - 58'd1));
      s2_in.tz = 24'(gz & ((58'd1 << FRAC_BITS) - 58'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         loaded_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         loaded_ff <= loaded_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_kind_ff <= kind;
         s1_lx_ff <= 33'(world_x) - 33'(origin_x);
         s1_lz_ff <= 33'(world_z) - 33'(origin_z);
         s1_idx_ff <= write_index;
         s1_data_ff <= sample_height;
         s1_loaded_ff <= loaded_ff;
      end
      if (adv2) s2_ff <= s2_in;
   end
endmodule

// ===== rtl/hmbs_queue.sv =====
// short queue between front and back parts
// depends on hmbs_pkg
module hmbs_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_stall,
   input  hmbs_pkg::cmd_type  wr_data,
   output logic               rd_valid,
   input  logic               rd_stall,
   output hmbs_pkg::cmd_type  rd_data
);
   localparam int AW = $clog2(DEPTH);
   hmbs_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff, cnt_in;
   logic wr, rd;

   assign wr_stall = cnt_ff == (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && !wr_stall;
   assign rd = rd_valid && !rd_stall;
   assign cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

// ===== rtl/hmbs_back.sv =====
// back part: banked grid store and pipelined bilinear blend
// depends on hmbs_pkg
module hmbs_back #(
   parameter int GRID_SIDE = hmbs_pkg::GRID_SIDE_DEF,
   parameter int FRAC_BITS = hmbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_stall,
   input  hmbs_pkg::cmd_type  cmd,
   output logic               out_valid,
   input  logic               out_stall,
   output logic signed [31:0] height,
   output logic               in_range
);
   localparam int CW = $clog2(GRID_SIDE);
   localparam int HS = (GRID_SIDE + 1) / 2;
   localparam int HW = (HS > 1) ? $clog2(HS) : 1;
   localparam int BD = HS * HS;
   localparam int BW = (BD > 1) ? $clog2(BD) : 1;
   localparam int RW = 2 * FRAC_BITS + 34;

   // four banks by row and column parity
   logic [31:0] bank00 [BD];
   logic [31:0] bank01 [BD];
   logic [31:0] bank10 [BD];
   logic [31:0] bank11 [BD];

   // pipeline: s0 read, s1 row blend, s2 column blend, s3 output
   logic v1_ff, v2_ff, v3_ff;
   logic adv;
   assign adv = !v3_ff || !out_stall;
   assign cmd_stall = !adv;

   logic go;
   assign go = cmd_valid && adv;

   // load address split
   logic [CW-1:0] lr, lc;
   logic [BW-1:0] la;
   always_comb begin
      lr = CW'(cmd.load_idx / 12'(GRID_SIDE));
      lc = CW'(cmd.load_idx % 12'(GRID_SIDE));
      la = BW'(32'(lr >> 1) * HS + 32'(lc >> 1));
   end

   // read addresses per bank for the four corners
   logic [CW:0] r0, c0, r1, c1;
   logic [HW-1:0] ar_e, ar_o, ac_e, ac_o;
   logic [BW-1:0] a00, a01, a10, a11;
   always_comb begin
      r0 = (CW+1)'(cmd.cz);
      c0 = (CW+1)'(cmd.cx);
      r1 = r0 + 1'b1;
      c1 = c0 + 1'b1;
      ar_e = r0[0] ? HW'(r1 >> 1) : HW'(r0 >> 1);
      ar_o = r0[0] ? HW'(r0 >> 1) : HW'(r1 >> 1);
      ac_e = c0[0] ? HW'(c1 >> 1) : HW'(c0 >> 1);
      ac_o = c0[0] ? HW'(c0 >> 1) : HW'(c1 >> 1);
      a00 = BW'(32'(ar_e) * HS + 32'(ac_e));
      a01 = BW'(32'(ar_e) * HS + 32'(ac_o));
      a10 = BW'(32'(ar_o) * HS + 32'(ac_e));
      a11 = BW'(32'(ar_o) * HS + 32'(ac_o));
   end

   logic [31:0] q00_ff, q01_ff, q10_ff, q11_ff;
   always_ff @(posedge clock) begin
      if (go && cmd.load_en) begin
         case ({lr[0], lc[0]})
            2'b00: bank00[la] <= cmd.load_data;
            2'b01: bank01[la] <= cmd.load_data;
            2'b10: bank10[la] <= cmd.load_data;
            default: bank11[la] <= cmd.load_data;
         endcase
      end
      if (adv) begin
         q00_ff <= bank00[a00];
         q01_ff <= bank01[a01];
         q10_ff <= bank10[a10];
         q11_ff <= bank11[a11];
      end
   end

   // stage 1 side info
   logic s1_ok_ff, s1_rp_ff, s1_cp_ff;
   logic [23:0] s1_tx_ff, s1_tz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff <= cmd.ok;
         s1_rp_ff <= r0[0];
         s1_cp_ff <= c0[0];
         s1_tx_ff <= cmd.tx;
         s1_tz_ff <= cmd.tz;
      end
   end

   logic [23:0] s2_tz_ff;

   // corner unscramble and row blend along x
   logic signed [31:0] h00, h01, h10, h11;
   logic signed [RW-1:0] one, tx, tz, rb0, rb1;
   always_comb begin
      h00 = s1_rp_ff ? (s1_cp_ff ? q11_ff : q10_ff) : (s1_cp_ff ? q01_ff : q00_ff);
      h01 = s1_rp_ff ? (s1_cp_ff ? q10_ff : q11_ff) : (s1_cp_ff ? q00_ff : q01_ff);
      h10 = s1_rp_ff ? (s1_cp_ff ? q01_ff : q00_ff) : (s1_cp_ff ? q11_ff : q10_ff);
      h11 = s1_rp_ff ? (s1_cp_ff ? q00_ff : q01_ff) : (s1_cp_ff ? q10_ff : q11_ff);
      one = RW'(1) <<< FRAC_BITS;
      tx = RW'({1'b0, s1_tx_ff});
      tz = RW'({1'b0, s2_tz_ff});
      rb0 = RW'(h00) * (one - tx) + RW'(h01) * tx;
      rb1 = RW'(h10) * (one - tx) + RW'(h11) * tx;
   end

   logic signed [RW-1:0] r0_ff, r1_ff;
   logic s2_ok_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff <= rb0;
         r1_ff <= rb1;
         s2_tz_ff <= s1_tz_ff;
         s2_ok_ff <= s1_ok_ff;
      end
   end

   // column blend along z and final floor shift
   logic signed [RW-1:0] zb;
   logic signed [RW-1:0] zs;
   always_comb begin
      zb = r0_ff * (one - tz) + r1_ff * tz;
      zs = zb >>> (2 * FRAC_BITS);
   end

   logic signed [31:0] hgt_ff;
   logic rng_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hgt_ff <= s2_ok_ff ? 32'(zs) : 32'sd0;
         rng_ff <= s2_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= go && cmd.is_query;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign height = hgt_ff;
   assign in_range = rng_ff;
endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Heightmap bilinear sampler. Loads write one grid sample (no result); queries
// map a world point into the grid and return the bilinear blend of the four
// surrounding samples, or 0 with in_range low when outside or before the last
// entry is loaded. One item per cycle sustained while rsp_stall is low; a query
// result passes two front mapping stages, one queue entry and three back stages
// (bank read, row blend, column blend) over four parity-banked sample memories.
// Depends on hmbs_pkg, hmbs_front, hmbs_queue, hmbs_back.
module heightmap_bilinear_sampler #(
   parameter int GRID_SIDE = hmbs_pkg::GRID_SIDE_DEF,
   parameter int FRAC_BITS = hmbs_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [11:0]         req_write_index,
   input  logic signed [31:0]  req_sample_height,
   input  logic signed [31:0]  req_world_x,
   input  logic signed [31:0]  req_world_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_height,
   output logic                rsp_in_range,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   // configuration registers
   logic signed [31:0] ox_ff, oz_ff;
   logic [23:0] cs_ff;
   logic wen;
   assign csr_pready = 1'b1;
   assign wen = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0;
         oz_ff <= '0;
         cs_ff <= hmbs_pkg::CELL_SCALE_RST;
      end else if (wen) begin
         case (csr_paddr)
            hmbs_pkg::REG_ORIGIN_X: ox_ff <= csr_pwdata;
            hmbs_pkg::REG_ORIGIN_Z: oz_ff <= csr_pwdata;
            hmbs_pkg::REG_CELL_SCALE: cs_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         hmbs_pkg::REG_ORIGIN_X: csr_prdata = ox_ff;
         hmbs_pkg::REG_ORIGIN_Z: csr_prdata = oz_ff;
         hmbs_pkg::REG_CELL_SCALE: csr_prdata = {8'd0, cs_ff};
         default: csr_prdata = '0;
      endcase
   end

   logic fv, fs, qv, qs;
   hmbs_pkg::cmd_type fc, qc;

   hmbs_front #(.GRID_SIDE(GRID_SIDE), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .kind(req_kind), .write_index(req_write_index),
      .sample_height(req_sample_height), .world_x(req_world_x),
      .world_z(req_world_z), .origin_x(ox_ff), .origin_z(oz_ff),
      .cell_scale(cs_ff), .cmd_valid(fv), .cmd_stall(fs), .cmd(fc)
   );

   hmbs_queue #(.DEPTH(4)) u_queue (
      .clock, .reset, .wr_valid(fv), .wr_stall(fs), .wr_data(fc),
      .rd_valid(qv), .rd_stall(qs), .rd_data(qc)
   );

   hmbs_back #(.GRID_SIDE(GRID_SIDE), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .cmd_valid(qv), .cmd_stall(qs), .cmd(qc),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .height(rsp_height),
      .in_range(rsp_in_range)
   );
endmodule

// ===== rtl/hmbs_checker.sv =====
// port-level checker for the heightmap bilinear sampler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module hmbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_height,
   input logic               rsp_in_range,
   input logic               csr_pready
);
   `CHK_IMPLY(a_out_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_height), "stalled result changed")
   `CHK_IMPLY(a_zero_out, clock, reset, rsp_valid && !rsp_in_range |-> rsp_height == 32'sd0, "out of range result not zero")
   `CHK_ALWAYS(a_ready, clock, csr_pready, "pready low")
   `CHK_IMPLY(a_rst_idle, clock, 1'b0, $past(reset) |-> !rsp_valid, "result after reset")
endmodule

bind heightmap_bilinear_sampler hmbs_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_height, .rsp_in_range, .csr_pready
);

// ===== test/tb_heightmap_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// testbench for heightmap_bilinear_sampler: loads the grid, runs directed and random queries
// across register settings and checks each result against a built-in bilinear predictor
// depends on hmbs_pkg and the heightmap_bilinear_sampler rtl
module tb_heightmap_bilinear_sampler;

   localparam int SIDE = 64;
   localparam int CELLS = SIDE * SIDE;
   localparam int FB = 16;
   localparam longint ONE = 64'sd1 << FB;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [31:0] height;
      logic               in_range;
   } sample_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = hmbs_pkg::KIND_LOAD;
   logic [11:0] req_write_index = '0;
   logic signed [31:0] req_sample_height = '0;
   logic signed [31:0] req_world_x = '0;
   logic signed [31:0] req_world_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_height;
   logic rsp_in_range;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic signed [31:0] grid_heights [CELLS];
   bit grid_full = 1'b0;
   logic signed [31:0] org_x = 32'sd0;
   logic signed [31:0] org_z = 32'sd0;
   logic [23:0] scale = hmbs_pkg::CELL_SCALE_RST;

   sample_result_type expected_heights[$];
   int error_count = 0;
   int cycle_count = 0;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   int recv_hold = 0;

   heightmap_bilinear_sampler i_dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("heightmap_bilinear_sampler verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic longint floor_div(input longint v);
      return v >>> FB;
   endfunction

   // world coordinate to grid cell and weight; 0 when outside
   function automatic bit map_axis(input logic signed [31:0] w, input logic signed [31:0] o,
                                  output int grid_cell, output longint frac);
      longint loc, prod, g;
      loc = longint'(w) - longint'(o);
      prod = loc * longint'({40'd0, scale});
      grid_cell = 0;
      frac = 0;
      if (prod < 0) return 1'b0;
      g = prod >>> (32 - FB);
      if (g >= (longint'(SIDE - 1) << FB)) return 1'b0;
      grid_cell = int'(g >>> FB);
      frac = g & (ONE - 1);
      return 1'b1;
   endfunction

   function automatic sample_result_type blend_heights(input logic signed [31:0] wx,
                                                      input logic signed [31:0] wz);
      sample_result_type r;
      int cx, cz;
      longint tx, tz, r0, r1, h0, h1, l0, l1, a, b;
      bit okx, okz;
      okx = map_axis(wx, org_x, cx, tx);
      okz = map_axis(wz, org_z, cz, tz);
      r.height = '0;
      r.in_range = 1'b0;
      if (!grid_full || !okx || !okz) return r;
      r0 = longint'(grid_heights[cz*SIDE+cx]) * (ONE - tx)
         + longint'(grid_heights[cz*SIDE+cx+1]) * tx;
      r1 = longint'(grid_heights[(cz+1)*SIDE+cx]) * (ONE - tx)
         + longint'(grid_heights[(cz+1)*SIDE+cx+1]) * tx;
      h0 = floor_div(r0);
      h1 = floor_div(r1);
      l0 = r0 - h0 * ONE;
      l1 = r1 - h1 * ONE;
      a = h0 * (ONE - tz) + h1 * tz;
      b = l0 * (ONE - tz) + l1 * tz;
      r.height = 32'(floor_div(a + floor_div(b)));
      r.in_range = 1'b1;
      return r;
   endfunction

   // send one item, predicting at acceptance; valid stays up for a following item
   task automatic send_item(input logic kind, input logic [11:0] idx,
                            input logic signed [31:0] hgt,
                            input logic signed [31:0] wx, input logic signed [31:0] wz);
      while (send_gaps && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_write_index <= idx;
      req_sample_height <= hgt;
      req_world_x <= wx;
      req_world_z <= wz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == hmbs_pkg::KIND_LOAD) begin
         if (idx < CELLS) begin
            grid_heights[idx] = hgt;
            if (idx == CELLS - 1) grid_full = 1'b1;
         end
      end else begin
         expected_heights.push_back(blend_heights(wx, wz));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      sample_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_heights.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            e = expected_heights.pop_front();
            if (rsp_height !== e.height)
               report_mismatch($sformatf("height %h expected %h", rsp_height, e.height));
            if (rsp_in_range !== e.in_range)
               report_mismatch($sformatf("in_range %b expected %b", rsp_in_range, e.in_range));
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_gaps && ($urandom_range(99) < 33);
      end
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; select stays up so writes can follow back to back
   task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
      case (addr)
         hmbs_pkg::REG_ORIGIN_X: org_x = data;
         hmbs_pkg::REG_ORIGIN_Z: org_z = data;
         hmbs_pkg::REG_CELL_SCALE: scale = data[23:0];
         default: ;
      endcase
   endtask

   task automatic set_mapping(input logic [31:0] ox, input logic [31:0] oz,
                              input logic [23:0] sc);
      wait_drained();
      write_reg(hmbs_pkg::REG_ORIGIN_X, ox);
      write_reg(hmbs_pkg::REG_ORIGIN_Z, oz);
      write_reg(hmbs_pkg::REG_CELL_SCALE, {8'd0, sc});
      csr_psel <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // world coordinate that lands inside the grid for the current mapping
   function automatic logic signed [31:0] inside_coord(input logic signed [31:0] o);
      longint span;
      span = (scale == 0) ? 64'd1000000 : ((longint'(SIDE - 1) << 32) / scale);
      return 32'(longint'(o) + longint'($urandom_range(32'(span > 0 ? span - 1 : 0))));
   endfunction

   function automatic logic signed [31:0] query_coord(input logic signed [31:0] o);
      if ($urandom_range(9) < 8) return inside_coord(o);
      return $urandom();
   endfunction

   // queries before the grid is complete, then a full load
   task automatic test_unloaded_then_load();
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'sd65536, 32'sd65536);
      send_item(hmbs_pkg::KIND_QUERY, 12'hfff, 0, 32'h7fffffff, 32'h80000000);
      for (int i = 0; i < CELLS; i++) begin
         logic signed [31:0] h;
         case (i % 7)
            0: h = 32'h7fffffff;
            1: h = 32'h80000000;
            default: h = $urandom();
         endcase
         send_item(hmbs_pkg::KIND_LOAD, 12'(i), h, $urandom(), $urandom());
      end
   endtask

   // extremes of the fields and the special cases
   task automatic test_directed();
      set_mapping(32'h0, 32'h0, 24'd65536);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'sd0, 32'sd0);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'sd62 << 16, 32'sd62 << 16);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'sd63 << 16, 32'sd0);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, (32'sd63 << 16) - 1, (32'sd63 << 16) - 1);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, -32'sd1, 32'sd5);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h7fffffff, 32'h7fffffff);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h80000000, 32'h80000000);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h00018000, 32'h00028000);
      set_mapping(32'h80000000, 32'h80000000, 24'd0);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h7fffffff, 32'h80000000);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, $urandom(), $urandom());
      set_mapping(32'h7fffffff, 32'h80000000, 24'hffffff);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h7fffffff, 32'h80000000);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h80000000, 32'h80000001);
      set_mapping(32'hff000000, 32'hff800000, 24'd1);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'h7fffffff, 32'h7fffffff);
      // the loaded flag stays set; rewriting keeps the grid valid
      send_item(hmbs_pkg::KIND_LOAD, 12'hfff, 32'h80000000, 0, 0);
      send_item(hmbs_pkg::KIND_LOAD, 12'd0, 32'h7fffffff, 0, 0);
      send_item(hmbs_pkg::KIND_QUERY, 12'd0, 0, 32'hff000000, 32'hff800000);
   endtask

   // random mix under one mapping
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 2)
            send_item(hmbs_pkg::KIND_LOAD, 12'($urandom()), $urandom(), $urandom(),
                      $urandom());
         else
            send_item(hmbs_pkg::KIND_QUERY, 12'($urandom()), $urandom(),
                      query_coord(org_x), query_coord(org_z));
      end
   endtask

   // receiver holds off long while items keep coming, then sender waits for drain
   task automatic test_backpressure();
      req_valid <= 1'b0;
      recv_hold <= 300;
      @(posedge clock);
      send_gaps = 1'b0;
      test_random(80);
      send_gaps = 1'b1;
      wait_drained();
      test_random(30);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unloaded_then_load();
      test_directed();
      set_mapping(32'hfff00000, 32'h00200000, hmbs_pkg::CELL_SCALE_RST);
      test_random(400);
      set_mapping($urandom(), $urandom(), 24'($urandom_range(16000, 200000)));
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      test_random(300);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      set_mapping(32'h0, 32'hffff0000, 24'd2000000);
      test_random(300);
      test_backpressure();
      set_mapping($urandom(), $urandom(), 24'($urandom()));
      test_random(300);
      wait_drained();
      if (error_count == 0)
         $display("heightmap_bilinear_sampler verification clean");
      else
         $display("heightmap_bilinear_sampler verification failed");
      $finish;
   end
endmodule
